// ----- rtl/tci_pkg.sv -----
// types, codes and constants shared by the turtle command interpreter
// no dependencies
package tci_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_REDUCE,
        S_QUAD,
        S_CORDIC,
        S_ROT,
        S_MUL,
        S_MOVE_FIN,
        S_SCALE_FIN,
        S_DIV,
        S_TURN,
        S_POP_LD,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [25:0] heading;
        logic signed [25:0] turn_step;
        logic signed [31:0] width;
        logic        [30:0] length;
        logic               swapped;
    } t_pose;

    // command symbols, latin-1
    localparam logic [7:0] SYM_DRAW    = 8'h46;  // F
    localparam logic [7:0] SYM_SKIP    = 8'h66;  // f
    localparam logic [7:0] SYM_LEFT    = 8'h2B;  // +
    localparam logic [7:0] SYM_RIGHT   = 8'h2D;  // -
    localparam logic [7:0] SYM_AROUND  = 8'h7C;  // |
    localparam logic [7:0] SYM_PUSH    = 8'h5B;  // [
    localparam logic [7:0] SYM_POP     = 8'h5D;  // ]
    localparam logic [7:0] SYM_WIDER   = 8'h23;  // #
    localparam logic [7:0] SYM_THINNER = 8'h21;  // !
    localparam logic [7:0] SYM_DOT     = 8'h40;  // @
    localparam logic [7:0] SYM_LONGER  = 8'h3E;  // >
    localparam logic [7:0] SYM_SHORTER = 8'h3C;  // <
    localparam logic [7:0] SYM_SWAP    = 8'h26;  // &
    localparam logic [7:0] SYM_STEP_DN = 8'h28;  // (
    localparam logic [7:0] SYM_STEP_UP = 8'h29;  // )

    // configuration register indexes
    localparam logic [2:0] CFG_START_HEADING = 3'd0;
    localparam logic [2:0] CFG_START_TURN    = 3'd1;
    localparam logic [2:0] CFG_TURN_CHANGE   = 3'd2;
    localparam logic [2:0] CFG_START_WIDTH   = 3'd3;
    localparam logic [2:0] CFG_WIDTH_CHANGE  = 3'd4;
    localparam logic [2:0] CFG_START_LENGTH  = 3'd5;
    localparam logic [2:0] CFG_LENGTH_SCALE  = 3'd6;

    localparam logic signed [26:0] DEG360 = 27'sd23592960;
    localparam logic signed [26:0] DEG180 = 27'sd11796480;
    localparam logic signed [26:0] DEG90  = 27'sd5898240;

    localparam logic signed [32:0] CORDIC_START = 33'sd652032874;
    localparam logic        [3:0]  CORDIC_LAST  = 4'd15;
    localparam logic        [5:0]  DIV_LAST     = 6'd47;
    localparam logic        [30:0] LEN_MAX      = 31'h7FFF_FFFF;

    // arctangent of 2^-i in q16 degrees
    function automatic logic signed [25:0] atan_deg(input logic [3:0] i);
        logic signed [25:0] r;
        case (i)
            4'd0:    r = 26'sd2949120;
            4'd1:    r = 26'sd1740967;
            4'd2:    r = 26'sd919879;
            4'd3:    r = 26'sd466945;
            4'd4:    r = 26'sd234379;
            4'd5:    r = 26'sd117266;
            4'd6:    r = 26'sd58666;
            4'd7:    r = 26'sd29335;
            4'd8:    r = 26'sd14668;
            4'd9:    r = 26'sd7334;
            4'd10:   r = 26'sd3667;
            4'd11:   r = 26'sd1833;
            4'd12:   r = 26'sd917;
            4'd13:   r = 26'sd458;
            4'd14:   r = 26'sd229;
            default: r = 26'sd115;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/tci_ram.sv -----
// generic single write port ram with registered read, used for the pose stack
// no dependencies
module tci_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/turtle_command_interpreter_top.sv -----
// turtle command interpreter top level: sequencer, shared cordic, multiply and divide steps
// depends on tci_pkg and tci_ram
//
// One command symbol is taken per request while o_stall is low; the block then raises
// o_stall until the symbol has been carried out. Steps per symbol: F and f fold the
// heading into [0, 360), split off whole quadrants, run 16 cordic iterations, make 4
// passes through the 33x17 multiplier, then update the position; < runs the
// one-bit-per-cycle restoring divider over a 48-bit dividend, or skips it for a zero
// scale; > makes two multiplier passes and the rounding step; turns and turn step
// changes fold the result into +/-360 degrees; ] waits for the registered stack read;
// all other symbols are carried out in the execute state. F and @ then hand the segment
// or dot to the output register, which waits there while i_stall is high.
// The pose stack is a ram of STACK_DEPTH entries with no clearing pass; its contents
// after reset are unknown and only entries below the fill count are ever popped.
// Configuration is taken on every cycle and must only be written while the block is idle.
module turtle_command_interpreter_top #(
    parameter int STACK_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command requests
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_symbol,
    input  logic               i_restart,
    // segment and dot results
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_kind,
    output logic signed [31:0] o_x_start,
    output logic signed [31:0] o_y_start,
    output logic signed [31:0] o_x_end,
    output logic signed [31:0] o_y_end,
    output logic signed [31:0] o_radius,
    // configuration writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [25:0]        i_cfg_data
);

    import tci_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int PW = $bits(t_pose);

    // sequencer and pose
    t_state             r_state, n_state;
    logic [7:0]         r_sym, n_sym;
    logic signed [31:0] r_pos_x, n_pos_x, r_pos_y, n_pos_y;
    logic signed [25:0] r_head, n_head, r_turn, n_turn;
    logic signed [31:0] r_width, n_width;
    logic [30:0]        r_len, n_len;
    logic               r_swap, n_swap;
    logic [CW-1:0]      r_cnt, n_cnt;

    // configuration registers
    logic signed [25:0] r_cfg_head, r_cfg_turn, r_cfg_tchg;
    logic [23:0]        r_cfg_wid, r_cfg_len, r_cfg_scale;
    logic [15:0]        r_cfg_wchg;

    // shared working registers
    logic signed [26:0] r_ang, n_ang;
    logic               r_tgt, n_tgt;        // fold result goes to turn step when set
    logic               r_mode, n_mode;      // multiplier use: move when clear, scale when set
    logic               r_kind, n_kind;
    logic [1:0]         r_quad, n_quad;
    logic signed [32:0] r_cx, n_cx, r_cy, n_cy;
    logic signed [25:0] r_cz, n_cz;
    logic [5:0]         r_iter, n_iter;
    logic signed [63:0] r_acc, n_acc;
    logic signed [33:0] r_dx, n_dx;
    logic signed [31:0] r_x0, n_x0, r_y0, n_y0;
    logic [47:0]        r_num, n_num;
    logic [23:0]        r_rem, n_rem;

    // output register
    logic               r_out_valid, n_out_valid;
    logic               r_out_kind, n_out_kind;
    logic signed [31:0] r_out_xs, n_out_xs, r_out_ys, n_out_ys;
    logic signed [31:0] r_out_xe, n_out_xe, r_out_ye, n_out_ye;
    logic signed [31:0] r_out_rad, n_out_rad;

    // stack ram
    logic          ram_we;
    logic [CW-1:0] cnt_dec;
    logic [AW-1:0] ram_raddr;
    logic [PW-1:0] ram_rdata;
    t_pose         cur_pose, pop_pose;

    // datapath helpers
    logic signed [32:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [49:0] prod;
    logic signed [63:0] prod_ext, prod_sh, rnd;
    logic signed [63:0] scaled;
    logic signed [32:0] sh_x, sh_y;
    logic [24:0]        rem2, rem_diff;
    logic               div_ge;
    logic [47:0]        num_next;

    assign cur_pose = '{x: r_pos_x, y: r_pos_y, heading: r_head, turn_step: r_turn,
                        width: r_width, length: r_len, swapped: r_swap};
    assign pop_pose  = t_pose'(ram_rdata);
    assign cnt_dec   = r_cnt - CW'(1);
    assign ram_raddr = cnt_dec[AW-1:0];

    tci_ram #(
        .WIDTH (PW),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (cur_pose),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // shared multiplier: cos/sin or scale factor times the low 16 or high 15 bits of the length
    assign mul_a    = r_mode ? $signed({9'd0, r_cfg_scale}) : (r_iter[1] ? r_cy : r_cx);
    assign mul_b    = r_iter[0] ? $signed({2'd0, r_len[30:16]}) : $signed({1'b0, r_len[15:0]});
    assign prod     = mul_a * mul_b;
    assign prod_ext = {{14{prod[49]}}, prod};
    assign prod_sh  = r_iter[0] ? (prod_ext <<< 16) : prod_ext;
    // q2.30 product back to q16.16, round half up
    assign rnd      = (r_acc + 64'sd536870912) >>> 30;
    assign scaled   = (r_acc + 64'sd32768) >>> 16;

    // cordic shifts
    assign sh_x = r_cx >>> r_iter[3:0];
    assign sh_y = r_cy >>> r_iter[3:0];

    // restoring divide step
    assign rem2     = {r_rem, r_num[47]};
    assign rem_diff = rem2 - {1'b0, r_cfg_scale};
    assign div_ge   = (rem2 >= {1'b0, r_cfg_scale});
    assign num_next = {r_num[46:0], div_ge};

    always_comb begin
        n_state = r_state;
        n_sym = r_sym;
        n_pos_x = r_pos_x;
        n_pos_y = r_pos_y;
        n_head = r_head;
        n_turn = r_turn;
        n_width = r_width;
        n_len = r_len;
        n_swap = r_swap;
        n_cnt = r_cnt;
        n_ang = r_ang;
        n_tgt = r_tgt;
        n_mode = r_mode;
        n_kind = r_kind;
        n_quad = r_quad;
        n_cx = r_cx;
        n_cy = r_cy;
        n_cz = r_cz;
        n_iter = r_iter;
        n_acc = r_acc;
        n_dx = r_dx;
        n_x0 = r_x0;
        n_y0 = r_y0;
        n_num = r_num;
        n_rem = r_rem;
        n_out_valid = r_out_valid;
        n_out_kind = r_out_kind;
        n_out_xs = r_out_xs;
        n_out_ys = r_out_ys;
        n_out_xe = r_out_xe;
        n_out_ye = r_out_ye;
        n_out_rad = r_out_rad;
        ram_we = 1'b0;

        // result taken downstream
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_sym = i_symbol;
                    n_state = S_EXEC;
                    // restart reloads the pose before the symbol runs
                    if (i_restart) begin
                        n_pos_x = '0;
                        n_pos_y = '0;
                        n_head = r_cfg_head;
                        n_turn = r_cfg_turn;
                        n_width = {8'd0, r_cfg_wid};
                        n_len = {7'd0, r_cfg_len};
                        n_swap = 1'b0;
                        n_cnt = '0;
                    end
                end
            end

            S_EXEC: begin
                n_state = S_IDLE;
                unique case (r_sym)
                    SYM_DRAW, SYM_SKIP: begin
                        n_kind = 1'b0;
                        n_x0 = r_pos_x;
                        n_y0 = r_pos_y;
                        n_ang = {r_head[25], r_head};
                        n_state = S_REDUCE;
                    end
                    SYM_LEFT, SYM_RIGHT: begin
                        n_tgt = 1'b0;
                        if ((r_sym == SYM_LEFT) != r_swap) begin
                            n_ang = {r_head[25], r_head} + {r_turn[25], r_turn};
                        end else begin
                            n_ang = {r_head[25], r_head} - {r_turn[25], r_turn};
                        end
                        n_state = S_TURN;
                    end
                    SYM_AROUND: begin
                        n_tgt = 1'b0;
                        n_ang = {r_head[25], r_head} + DEG180;
                        n_state = S_TURN;
                    end
                    SYM_STEP_DN: begin
                        n_tgt = 1'b1;
                        n_ang = {r_turn[25], r_turn} - {r_cfg_tchg[25], r_cfg_tchg};
                        n_state = S_TURN;
                    end
                    SYM_STEP_UP: begin
                        n_tgt = 1'b1;
                        n_ang = {r_turn[25], r_turn} + {r_cfg_tchg[25], r_cfg_tchg};
                        n_state = S_TURN;
                    end
                    SYM_PUSH: begin
                        // full stack drops the push
                        if (r_cnt < CW'(STACK_DEPTH)) begin
                            ram_we = 1'b1;
                            n_cnt = r_cnt + CW'(1);
                        end
                    end
                    SYM_POP: begin
                        // read of the top entry is under way, load it next cycle
                        if (r_cnt != '0) begin
                            n_cnt = cnt_dec;
                            n_state = S_POP_LD;
                        end
                    end
                    SYM_WIDER: begin
                        n_width = sat32(64'(r_width) + 64'(r_cfg_wchg));
                    end
                    SYM_THINNER: begin
                        n_width = sat32(64'(r_width) - 64'(r_cfg_wchg));
                    end
                    SYM_DOT: begin
                        n_kind = 1'b1;
                        n_x0 = r_pos_x;
                        n_y0 = r_pos_y;
                        n_state = S_EMIT;
                    end
                    SYM_LONGER: begin
                        n_mode = 1'b1;
                        n_iter = '0;
                        n_state = S_MUL;
                    end
                    SYM_SHORTER: begin
                        if (r_cfg_scale == '0) begin
                            n_len = LEN_MAX;
                        end else begin
                            n_num = {1'b0, r_len, 16'd0} + {25'd0, r_cfg_scale[23:1]};
                            n_rem = '0;
                            n_iter = '0;
                            n_state = S_DIV;
                        end
                    end
                    SYM_SWAP: begin
                        n_swap = !r_swap;
                    end
                    default: begin
                    end
                endcase
            end

            // heading into [0, 360)
            S_REDUCE: begin
                if (r_ang >= DEG360) begin
                    n_ang = r_ang - DEG360;
                end else if (r_ang < 27'sd0) begin
                    n_ang = r_ang + DEG360;
                end else begin
                    n_quad = 2'd0;
                    n_state = S_QUAD;
                end
            end

            // split off whole quadrants
            S_QUAD: begin
                if (r_ang >= DEG90) begin
                    n_ang = r_ang - DEG90;
                    n_quad = r_quad + 2'd1;
                end else begin
                    n_cz = r_ang[25:0];
                    n_cx = CORDIC_START;
                    n_cy = '0;
                    n_iter = '0;
                    n_state = S_CORDIC;
                end
            end

            S_CORDIC: begin
                if (r_cz >= 26'sd0) begin
                    n_cx = r_cx - sh_y;
                    n_cy = r_cy + sh_x;
                    n_cz = r_cz - atan_deg(r_iter[3:0]);
                end else begin
                    n_cx = r_cx + sh_y;
                    n_cy = r_cy - sh_x;
                    n_cz = r_cz + atan_deg(r_iter[3:0]);
                end
                n_iter = r_iter + 6'd1;
                if (r_iter[3:0] == CORDIC_LAST) begin
                    n_state = S_ROT;
                end
            end

            // quadrant rotation: cx holds cos, cy holds sin afterwards
            S_ROT: begin
                case (r_quad)
                    2'd0: begin
                        n_cx = r_cx;
                        n_cy = r_cy;
                    end
                    2'd1: begin
                        n_cx = -r_cy;
                        n_cy = r_cx;
                    end
                    2'd2: begin
                        n_cx = -r_cx;
                        n_cy = -r_cy;
                    end
                    default: begin
                        n_cx = r_cy;
                        n_cy = -r_cx;
                    end
                endcase
                n_mode = 1'b0;
                n_iter = '0;
                n_state = S_MUL;
            end

            // low half then high half; move does cos pair then sin pair
            S_MUL: begin
                if (!r_iter[0]) begin
                    n_acc = prod_sh;
                    if (r_iter[1]) begin
                        n_dx = rnd[33:0];
                    end
                end else begin
                    n_acc = r_acc + prod_sh;
                end
                n_iter = r_iter + 6'd1;
                if (r_mode && r_iter[0]) begin
                    n_state = S_SCALE_FIN;
                end else if (r_iter[1] && r_iter[0]) begin
                    n_state = S_MOVE_FIN;
                end
            end

            S_MOVE_FIN: begin
                n_pos_x = sat32(64'(r_pos_x) + 64'(r_dx));
                n_pos_y = sat32(64'(r_pos_y) - rnd);
                n_state = (r_sym == SYM_DRAW) ? S_EMIT : S_IDLE;
            end

            S_SCALE_FIN: begin
                if (scaled > $signed({33'd0, LEN_MAX})) begin
                    n_len = LEN_MAX;
                end else begin
                    n_len = scaled[30:0];
                end
                n_state = S_IDLE;
            end

            S_DIV: begin
                n_rem = div_ge ? rem_diff[23:0] : rem2[23:0];
                n_num = num_next;
                n_iter = r_iter + 6'd1;
                if (r_iter == DIV_LAST) begin
                    n_len = (num_next[47:31] != '0) ? LEN_MAX : num_next[30:0];
                    n_state = S_IDLE;
                end
            end

            // fold toward zero, remainder keeps the sign of the sum
            S_TURN: begin
                if (r_ang >= DEG360) begin
                    n_ang = r_ang - DEG360;
                end else if (r_ang <= -DEG360) begin
                    n_ang = r_ang + DEG360;
                end else begin
                    if (r_tgt) begin
                        n_turn = r_ang[25:0];
                    end else begin
                        n_head = r_ang[25:0];
                    end
                    n_state = S_IDLE;
                end
            end

            S_POP_LD: begin
                n_pos_x = pop_pose.x;
                n_pos_y = pop_pose.y;
                n_head = pop_pose.heading;
                n_turn = pop_pose.turn_step;
                n_width = pop_pose.width;
                n_len = pop_pose.length;
                n_swap = pop_pose.swapped;
                n_state = S_IDLE;
            end

            // wait for room in the output register
            S_EMIT: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_kind = r_kind;
                    n_out_xs = r_x0;
                    n_out_ys = r_y0;
                    n_out_xe = r_pos_x;
                    n_out_ye = r_pos_y;
                    n_out_rad = r_width;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state, pose and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_head <= 26'sd5898240;
            r_turn <= 26'sd5898240;
            r_width <= 32'sd65536;
            r_len <= 31'd65536;
            r_swap <= 1'b0;
            r_cnt <= '0;
            r_cfg_head <= 26'sd5898240;
            r_cfg_turn <= 26'sd5898240;
            r_cfg_tchg <= '0;
            r_cfg_wid <= 24'd65536;
            r_cfg_wchg <= 16'd3277;
            r_cfg_len <= 24'd65536;
            r_cfg_scale <= 24'd78643;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
            r_head <= n_head;
            r_turn <= n_turn;
            r_width <= n_width;
            r_len <= n_len;
            r_swap <= n_swap;
            r_cnt <= n_cnt;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_START_HEADING: r_cfg_head <= i_cfg_data;
                    CFG_START_TURN:    r_cfg_turn <= i_cfg_data;
                    CFG_TURN_CHANGE:   r_cfg_tchg <= i_cfg_data;
                    CFG_START_WIDTH:   r_cfg_wid <= i_cfg_data[23:0];
                    CFG_WIDTH_CHANGE:  r_cfg_wchg <= i_cfg_data[15:0];
                    CFG_START_LENGTH:  r_cfg_len <= i_cfg_data[23:0];
                    CFG_LENGTH_SCALE:  r_cfg_scale <= i_cfg_data[23:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // working and result payload
    always_ff @(posedge i_clk) begin
        r_sym <= n_sym;
        r_ang <= n_ang;
        r_tgt <= n_tgt;
        r_mode <= n_mode;
        r_kind <= n_kind;
        r_quad <= n_quad;
        r_cx <= n_cx;
        r_cy <= n_cy;
        r_cz <= n_cz;
        r_iter <= n_iter;
        r_acc <= n_acc;
        r_dx <= n_dx;
        r_x0 <= n_x0;
        r_y0 <= n_y0;
        r_num <= n_num;
        r_rem <= n_rem;
        r_out_kind <= n_out_kind;
        r_out_xs <= n_out_xs;
        r_out_ys <= n_out_ys;
        r_out_xe <= n_out_xe;
        r_out_ye <= n_out_ye;
        r_out_rad <= n_out_rad;
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_x_start   = r_out_xs;
    assign o_y_start   = r_out_ys;
    assign o_x_end     = r_out_xe;
    assign o_y_end     = r_out_ye;
    assign o_radius    = r_out_rad;

endmodule

// ----- rtl/tci_checker.sv -----
// port-level checks for the turtle command interpreter, bound to the top level
// depends on turtle_command_interpreter_top
module tci_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic               o_kind,
    input logic signed [31:0] o_x_start,
    input logic signed [31:0] o_y_start,
    input logic signed [31:0] o_x_end,
    input logic signed [31:0] o_y_end
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_x_start) && $stable(o_x_end))
        else $error("stalled result changed");

    // a dot has no extent
    a_dot_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind |-> o_x_start == o_x_end && o_y_start == o_y_end)
        else $error("dot with differing ends");

    // every accepted request makes the block busy on the next cycle
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("request taken without busy cycle");

    // a new result only appears out of a busy cycle
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared while idle");

endmodule

bind turtle_command_interpreter_top tci_checker u_tci_checker (.*);

// ----- test/turtle_command_interpreter_top_tb.sv -----
// self-checking testbench for the turtle command interpreter: command stimulus,
// config phases, segment/dot checking against a behavioral pose model
// depends on tci_pkg and the turtle_command_interpreter_top rtl
module turtle_command_interpreter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tci_pkg::*;

    typedef struct {
        logic               kind;
        logic signed [31:0] xs, ys, xe, ye, rad;
    } seg_t;

    // scoreboard: holds the turtle pose model and the queue of expected segments
    class segment_scoreboard;
        seg_t          pending[$];
        int            errors;
        logic [25:0]   cfg[7];
        longint        px, py, hd, ts, wd, ln;
        bit            swp;
        longint        sx[64], sy[64], sh[64], st[64], sw[64], sl[64];
        bit            ss[64];
        int            depth;

        function automatic longint sx26(logic [25:0] v);
            return longint'(signed'(v));
        endfunction

        function automatic longint sat(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function automatic longint sat_len(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < 0) return 0;
            return v;
        endfunction

        function automatic longint floor_shift(longint v, int s);
            return v >>> s;
        endfunction

        function void restart_pose();
            px = 0; py = 0;
            hd = sx26(cfg[CFG_START_HEADING]);
            ts = sx26(cfg[CFG_START_TURN]);
            wd = longint'(cfg[CFG_START_WIDTH][23:0]);
            ln = longint'(cfg[CFG_START_LENGTH][23:0]);
            swp = 0; depth = 0;
        endfunction

        function void reset_all();
            cfg[CFG_START_HEADING] = 26'd5898240;
            cfg[CFG_START_TURN]    = 26'd5898240;
            cfg[CFG_TURN_CHANGE]   = 26'd0;
            cfg[CFG_START_WIDTH]   = 26'd65536;
            cfg[CFG_WIDTH_CHANGE]  = 26'd3277;
            cfg[CFG_START_LENGTH]  = 26'd65536;
            cfg[CFG_LENGTH_SCALE]  = 26'd78643;
            errors = 0;
            restart_pose();
        endfunction

        function void write_reg(logic [2:0] idx, logic [25:0] d);
            case (idx)
                CFG_START_HEADING, CFG_START_TURN, CFG_TURN_CHANGE: cfg[idx] = d;
                CFG_WIDTH_CHANGE: cfg[idx] = {10'd0, d[15:0]};
                CFG_START_WIDTH, CFG_START_LENGTH, CFG_LENGTH_SCALE:
                    cfg[idx] = {2'd0, d[23:0]};
                default: ;
            endcase
        endfunction

        // cordic sine/cosine of the heading in q2.30
        function void heading_trig(output longint c, output longint s);
            longint a, q, z, x, y, nx;
            longint atn[16] = '{2949120, 1740967, 919879, 466945, 234379, 117266,
                                58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                229, 115};
            a = hd % 64'sd23592960;
            if (a < 0) a += 64'sd23592960;
            q = a / 64'sd5898240;
            z = a - q * 64'sd5898240;
            x = 64'sd652032874; y = 0;
            for (int i = 0; i < 16; i++) begin
                if (z >= 0) begin
                    nx = x - floor_shift(y, i); y = y + floor_shift(x, i); z -= atn[i];
                end else begin
                    nx = x + floor_shift(y, i); y = y - floor_shift(x, i); z += atn[i];
                end
                x = nx;
            end
            case (q)
                0: begin c = x; s = y; end
                1: begin c = -y; s = x; end
                2: begin c = -x; s = -y; end
                default: begin c = y; s = -x; end
            endcase
        endfunction

        function void advance();
            longint c, s;
            heading_trig(c, s);
            px = sat(px + floor_shift(ln * c + (64'sd1 << 29), 30));
            py = sat(py - floor_shift(ln * s + (64'sd1 << 29), 30));
        endfunction

        // note an accepted command and queue what it should produce
        function void note_command(logic [7:0] sym, logic rst);
            seg_t   e;
            longint sc;
            bit     lft;
            if (rst) restart_pose();
            case (sym)
                SYM_DRAW: begin
                    e.kind = 1'b0; e.xs = 32'(px); e.ys = 32'(py);
                    advance();
                    e.xe = 32'(px); e.ye = 32'(py); e.rad = 32'(wd);
                    pending.push_back(e);
                end
                SYM_SKIP: advance();
                SYM_LEFT, SYM_RIGHT: begin
                    lft = (sym == SYM_LEFT) != swp;
                    hd = lft ? (hd + ts) % 64'sd23592960 : (hd - ts) % 64'sd23592960;
                end
                SYM_AROUND: hd = (hd + 64'sd11796480) % 64'sd23592960;
                SYM_PUSH: if (depth < 64) begin
                    sx[depth] = px; sy[depth] = py; sh[depth] = hd; st[depth] = ts;
                    sw[depth] = wd; sl[depth] = ln; ss[depth] = swp;
                    depth++;
                end
                SYM_POP: if (depth > 0) begin
                    depth--;
                    px = sx[depth]; py = sy[depth]; hd = sh[depth]; ts = st[depth];
                    wd = sw[depth]; ln = sl[depth]; swp = ss[depth];
                end
                SYM_WIDER:   wd = sat(wd + longint'(cfg[CFG_WIDTH_CHANGE]));
                SYM_THINNER: wd = sat(wd - longint'(cfg[CFG_WIDTH_CHANGE]));
                SYM_DOT: begin
                    e.kind = 1'b1; e.xs = 32'(px); e.ys = 32'(py);
                    e.xe = 32'(px); e.ye = 32'(py); e.rad = 32'(wd);
                    pending.push_back(e);
                end
                SYM_LONGER: begin
                    sc = longint'(cfg[CFG_LENGTH_SCALE]);
                    ln = sat_len((ln * sc + 64'sd32768) >>> 16);
                end
                SYM_SHORTER: begin
                    sc = longint'(cfg[CFG_LENGTH_SCALE]);
                    ln = (sc == 0) ? 64'sd2147483647 : sat_len((ln * 65536 + sc / 2) / sc);
                end
                SYM_SWAP: swp = !swp;
                SYM_STEP_DN: ts = (ts - sx26(cfg[CFG_TURN_CHANGE])) % 64'sd23592960;
                SYM_STEP_UP: ts = (ts + sx26(cfg[CFG_TURN_CHANGE])) % 64'sd23592960;
                default: ;
            endcase
        endfunction

        function void cmp(string nm, longint ex, longint ac);
            if (ex != ac) begin
                $display("%0t: %s expected %0d actual %0d", $time, nm, ex, ac);
                errors++;
            end
        endfunction

        // check one accepted result against the oldest expectation
        function void check_result(seg_t a);
            seg_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result expected none actual kind %0d", $time,
                         a.kind);
                errors++;
                return;
            end
            e = pending.pop_front();
            cmp("kind", e.kind, a.kind);
            cmp("x_start", e.xs, a.xs);
            cmp("y_start", e.ys, a.ys);
            cmp("x_end", e.xe, a.xe);
            cmp("y_end", e.ye, a.ye);
            cmp("radius", e.rad, a.rad);
        endfunction
    endclass

    logic               clk = 0, rst_n = 0;
    logic               cmd_valid = 0, cmd_stall;
    logic [7:0]         cmd_symbol = 0;
    logic               cmd_restart = 0;
    logic               seg_valid, seg_stall = 0, seg_kind;
    logic signed [31:0] seg_xs, seg_ys, seg_xe, seg_ye, seg_rad;
    logic               cfg_valid = 0, cfg_ready;
    logic [2:0]         cfg_index = 0;
    logic [25:0]        cfg_data = 0;

    segment_scoreboard board = new();
    bit                no_rx_idle;    // stretches where the receiver never stalls
    bit                no_tx_idle;

    always #1 clk = ~clk;

    turtle_command_interpreter_top u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(cmd_valid), .o_stall(cmd_stall),
        .i_symbol(cmd_symbol), .i_restart(cmd_restart),
        .o_valid(seg_valid), .i_stall(seg_stall), .o_kind(seg_kind),
        .o_x_start(seg_xs), .o_y_start(seg_ys), .o_x_end(seg_xe), .o_y_end(seg_ye),
        .o_radius(seg_rad),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    // result side: random stall per result, check on acceptance
    initial begin
        int   gap;
        seg_t r;
        forever begin
            @(posedge clk);
            if (seg_valid && !seg_stall) begin
                r.kind = seg_kind; r.xs = seg_xs; r.ys = seg_ys;
                r.xe = seg_xe; r.ye = seg_ye; r.rad = seg_rad;
                board.check_result(r);
                gap = no_rx_idle ? 0 : $urandom_range(0, 5);
                seg_stall <= (gap != 0);
            end else if (seg_stall) begin
                if (gap > 0) gap--;
                seg_stall <= (gap > 0) && !no_rx_idle;
            end
        end
    end

    // one command request; gap drawn per item, accepted at valid and not stall
    // valid stays high after acceptance so back to back requests need no extra edge
    task automatic send_command(logic [7:0] sym, logic rst);
        int gap;
        gap = no_tx_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            cmd_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid   <= 1;
        cmd_symbol  <= sym;
        cmd_restart <= rst;
        do @(posedge clk); while (cmd_stall);
        board.note_command(sym, rst);
    endtask

    // valid is left high; the caller drops it after the last write
    task automatic write_config(logic [2:0] idx, logic [25:0] d);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        board.write_reg(idx, d);
    endtask

    // wait out every expected result, then the longest command latency
    task automatic drain();
        cmd_valid <= 0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    localparam logic [7:0] CMD_SET[15] = '{SYM_DRAW, SYM_SKIP, SYM_LEFT, SYM_RIGHT,
        SYM_AROUND, SYM_PUSH, SYM_POP, SYM_WIDER, SYM_THINNER, SYM_DOT, SYM_LONGER,
        SYM_SHORTER, SYM_SWAP, SYM_STEP_DN, SYM_STEP_UP};

    // mostly meaningful commands, draws and dots weighted up, some raw bytes
    function automatic logic [7:0] pick_symbol();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return SYM_DRAW;
        if (r < 32) return SYM_DOT;
        if (r < 90) return CMD_SET[$urandom_range(0, 14)];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [25:0] angle_value();
        case ($urandom_range(0, 3))
            0: return 26'(-23592960);
            1: return 26'd23592960;
            2: return 26'($urandom_range(0, 47185920) - 23592960);
            default: return 26'($urandom);   // raw bits, folded on next turn
        endcase
    endfunction

    function automatic logic [25:0] reg_value(logic [2:0] idx, int extreme);
        case (idx)
            CFG_START_HEADING, CFG_START_TURN, CFG_TURN_CHANGE:
                return extreme == 1 ? 26'(-23592960) :
                       extreme == 2 ? 26'd23592960 : angle_value();
            CFG_WIDTH_CHANGE:
                return extreme == 1 ? 26'd0 : extreme == 2 ? 26'd65535 :
                       26'($urandom_range(0, 65535));
            CFG_LENGTH_SCALE:
                return extreme == 1 ? 26'd0 : extreme == 2 ? 26'hFFFFFF :
                       26'($urandom_range(1, 200000));
            default:
                return extreme == 1 ? 26'd0 : extreme == 2 ? 26'hFFFFFF :
                       26'($urandom_range(0, 1 << 20));
        endcase
    endfunction

    initial begin
        board.reset_all();
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: every command, pop on empty, push overflow
        send_command(SYM_POP, 0);
        send_command(SYM_DOT, 0);
        for (int i = 0; i < 15; i++) send_command(CMD_SET[i], 0);
        send_command(8'h7B, 0);   // braces are ignored
        send_command(8'hFF, 1);
        for (int i = 0; i < 66; i++) send_command(SYM_PUSH, 0);   // full stack drops
        send_command(SYM_DRAW, 0);
        drain();

        // phases: extremes first, then random settings
        for (int ph = 0; ph < 10; ph++) begin
            no_tx_idle = (ph % 4 == 3);
            no_rx_idle = (ph % 4 == 2);
            for (int k = 0; k < 7; k++)
                write_config(3'(k), reg_value(3'(k), ph < 2 ? ph + 1 : 0));
            cfg_valid <= 0;
            send_command(SYM_DRAW, 1);
            for (int n = 0; n < 106; n++)
                send_command(pick_symbol(), ($urandom_range(0, 29) == 0));
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // timeout: about 1200 items plus stalls, many times over
    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/tci_pkg.sv
rtl/tci_ram.sv
rtl/turtle_command_interpreter_top.sv
rtl/tci_checker.sv
test/turtle_command_interpreter_top_tb.sv
